### design/multi_stack_first_fit_macros.svh
// assertion macros used by the back-end design file
`ifndef MULTI_STACK_FIRST_FIT_MACROS_SVH
`define MULTI_STACK_FIRST_FIT_MACROS_SVH
`ifndef ASSERT_OFF
`define MSFF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define MSFF_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define MSFF_ASSERT(label, clk, rst_n, prop, msg)
`define MSFF_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg)
`endif
`endif

### design/msff_pkg.sv
package msff_pkg;

    localparam int VALUE_W   = 16;
    localparam int INDEX_W   = 6;
    localparam int STATUS_W  = 2;
    localparam int FUNC_W    = 2;
    localparam int CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_POP_AT = 2'd2,
        FUNC_NOP    = 2'd3
    } func_e;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_e;

    typedef enum logic [2:0] {
        OP_PUSH     = 3'd0,
        OP_POP_LAST = 3'd1,
        OP_POP_AT   = 3'd2,
        OP_NOP      = 3'd3,
        OP_MISS     = 3'd4
    } op_kind_e;

    typedef enum logic {
        BK_EXEC   = 1'b0,
        BK_FINISH = 1'b1
    } back_state_e;

    typedef struct packed {
        op_kind_e           kind;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } op_t;

endpackage

### design/msff_channels.sv
interface msff_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] push_value;
    logic [5:0]  stack_index;

    modport source (output valid, func, push_value, stack_index, input ready);
    modport sink (input valid, func, push_value, stack_index, output ready);
endinterface

interface msff_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] pop_value;
    logic [1:0]  status;

    modport source (output valid, pop_value, status, input ready);
    modport sink (input valid, pop_value, status, output ready);
endinterface

interface msff_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### design/msff_front.sv
module msff_front #(
    parameter int NUM_STACKS = 64
) (
    msff_req_if.sink         req,
    output logic             q_valid,
    input  logic             q_ready,
    output msff_pkg::op_t    q_op
);
    import msff_pkg::*;

    logic index_ok;

    assign index_ok = 32'(req.stack_index) < NUM_STACKS;

    // decode the request into an operation for the back end
    always_comb
    begin
        q_op.value = req.push_value;
        q_op.index = req.stack_index;
        case (func_e'(req.func))
            FUNC_PUSH:   q_op.kind = OP_PUSH;
            FUNC_POP:    q_op.kind = OP_POP_LAST;
            FUNC_POP_AT: q_op.kind = index_ok ? OP_POP_AT : OP_MISS;
            FUNC_NOP:    q_op.kind = OP_NOP;
            default:     q_op.kind = OP_NOP;
        endcase
    end

    assign q_valid   = req.valid;
    assign req.ready = q_ready;

endmodule

### design/msff_queue.sv
module msff_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  msff_pkg::op_t push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output msff_pkg::op_t pop_op
);
    import msff_pkg::*;

    op_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = count_reg != (Q_PTR_W+1)'(Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### design/msff_back.sv
`include "multi_stack_first_fit_macros.svh"

module msff_back #(
    parameter int NUM_STACKS = 64,
    parameter int CAP_MAX    = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  msff_pkg::op_t                  q_op,
    input  logic [$clog2(CAP_MAX+1)-1:0]   eff_cap,
    msff_rsp_if.source                     rsp
);
    import msff_pkg::*;

    localparam int IDX_W  = $clog2(NUM_STACKS);
    localparam int FILL_W = $clog2(CAP_MAX + 1);
    localparam int DEPTH  = NUM_STACKS * CAP_MAX;
    localparam int ADDR_W = $clog2(DEPTH);

    back_state_e state_reg, state_next;

    logic [FILL_W-1:0]     fill_reg  [NUM_STACKS];
    logic [FILL_W-1:0]     fill_next [NUM_STACKS];
    logic [NUM_STACKS-1:0] full_reg, full_next;
    logic [NUM_STACKS-1:0] used_reg, used_next;

    logic [NUM_STACKS-1:0] free_vec, free_low, used_rev, used_rev_low, last_oh, at_oh;
    logic [IDX_W-1:0]      free_idx, last_idx, at_idx;
    logic [NUM_STACKS-1:0] tgt_oh;
    logic [IDX_W-1:0]      tgt_idx;
    logic                  do_inc, do_dec;
    status_e               status_d;
    logic [FILL_W-1:0]     fill_sel, level;
    logic [ADDR_W-1:0]     addr;

    logic                  q_pop, load_out, out_free;

    logic [DATA_WIDTH-1:0] plate_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  pop_ok_reg;
    status_e               status_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]    out_value_reg;
    status_e               out_status_reg;

    // lowest stack with room
    assign free_vec = ~full_reg;
    assign free_low = free_vec & (~free_vec + 1'b1);

    // highest stack holding a value, found by isolating the lowest bit of the mirror
    always_comb
    begin
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            used_rev[s] = used_reg[NUM_STACKS-1-s];
        end
    end

    assign used_rev_low = used_rev & (~used_rev + 1'b1);

    always_comb
    begin
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            last_oh[s] = used_rev_low[NUM_STACKS-1-s];
        end
    end

    assign at_idx = IDX_W'(q_op.index);

    always_comb
    begin
        free_idx = '0;
        last_idx = '0;
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            at_oh[s] = at_idx == IDX_W'(s);
            if (free_low[s])
            begin
                free_idx = free_idx | IDX_W'(s);
            end
            if (last_oh[s])
            begin
                last_idx = last_idx | IDX_W'(s);
            end
        end
    end

    // pick the target stack and the outcome
    always_comb
    begin
        tgt_oh   = '0;
        tgt_idx  = '0;
        do_inc   = 1'b0;
        do_dec   = 1'b0;
        status_d = STATUS_OK;
        case (q_op.kind)
            OP_PUSH:
            begin
                if (|free_vec)
                begin
                    tgt_oh  = free_low;
                    tgt_idx = free_idx;
                    do_inc  = 1'b1;
                end
                else
                begin
                    status_d = STATUS_FULL;
                end
            end
            OP_POP_LAST:
            begin
                if (|used_reg)
                begin
                    tgt_oh  = last_oh;
                    tgt_idx = last_idx;
                    do_dec  = 1'b1;
                end
                else
                begin
                    status_d = STATUS_EMPTY;
                end
            end
            OP_POP_AT:
            begin
                if (used_reg[at_idx])
                begin
                    tgt_oh  = at_oh;
                    tgt_idx = at_idx;
                    do_dec  = 1'b1;
                end
                else
                begin
                    status_d = STATUS_EMPTY;
                end
            end
            OP_MISS:
            begin
                status_d = STATUS_EMPTY;
            end
            OP_NOP:
            begin
                status_d = STATUS_OK;
            end
            default:
            begin
                status_d = STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        fill_sel = '0;
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            fill_sel = fill_sel | (tgt_oh[s] ? fill_reg[s] : '0);
        end
    end

    assign level = do_inc ? fill_sel : fill_sel - FILL_W'(1);
    assign addr  = ADDR_W'(tgt_idx) * ADDR_W'(CAP_MAX) + ADDR_W'(level);

    // per-stack fill lanes and their flags
    always_comb
    begin
        for (int s = 0; s < NUM_STACKS; s++)
        begin
            fill_next[s] = fill_reg[s];
            if (q_pop && tgt_oh[s] && do_inc)
            begin
                fill_next[s] = fill_reg[s] + FILL_W'(1);
            end
            else if (q_pop && tgt_oh[s] && do_dec)
            begin
                fill_next[s] = fill_reg[s] - FILL_W'(1);
            end
            full_next[s] = fill_next[s] >= eff_cap;
            used_next[s] = fill_next[s] != '0;
        end
    end

    // sequencer
    always_comb
    begin
        case (state_reg)
            BK_EXEC:   state_next = q_pop ? BK_FINISH : BK_EXEC;
            BK_FINISH: state_next = BK_EXEC;
            default:   state_next = BK_EXEC;
        endcase
    end

    always_comb
    begin
        out_free = !out_valid_reg || rsp.ready;
        case (state_reg)
            BK_EXEC:
            begin
                q_pop    = q_valid && out_free;
                load_out = 1'b0;
            end
            BK_FINISH:
            begin
                q_pop    = 1'b0;
                load_out = 1'b1;
            end
            default:
            begin
                q_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign q_ready = q_pop;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_EXEC;
            full_reg      <= '0;
            used_reg      <= '0;
            pop_ok_reg    <= 1'b0;
            status_reg    <= STATUS_OK;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < NUM_STACKS; s++)
            begin
                fill_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            full_reg      <= full_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
            if (q_pop)
            begin
                pop_ok_reg <= do_dec;
                status_reg <= status_d;
            end
        end
    end

    // plate store, single port
    always_ff @(posedge clk)
    begin
        if (q_pop && do_inc)
        begin
            plate_mem[addr] <= DATA_WIDTH'(q_op.value);
        end
        if (q_pop && do_dec)
        begin
            rd_data_reg <= plate_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg  <= pop_ok_reg ? VALUE_W'(rd_data_reg) : '0;
            out_status_reg <= status_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.pop_value = out_value_reg;
    assign rsp.status    = out_status_reg;

    `MSFF_ASSERT(a_target_onehot, clk, rst_n, $onehot0(tgt_oh), "target select not one-hot")
    `MSFF_ASSERT(a_pop_nonempty, clk, rst_n, (q_pop && do_dec) |-> (fill_sel != '0), "pop from empty stack")
    `MSFF_ASSERT(a_finish_slot_free, clk, rst_n, (state_reg == BK_FINISH) |-> !out_valid_reg, "result register busy at finish")
    `MSFF_ASSERT_NEXT(a_exec_to_finish, clk, rst_n, q_pop, state_reg == BK_FINISH, "issued op did not finish")

endmodule

### design/multi_stack_first_fit.sv
// a request is written into the queue; the back end issues it in its execute state, with the select-and-update
// step and the registered read of the single-port plate store, and loads the result register in its finish
//   state; it takes no new operation until the last one has finished and the result register is free
// reset: rst_n async active low; fills cleared, capacity 16, queue and result register empty
// the plate store is not cleared; only entries below a fill count are ever read
module multi_stack_first_fit #(
    parameter int NUM_STACKS = 64,
    parameter int CAP_MAX    = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    msff_req_if.sink   req,
    msff_rsp_if.source rsp,
    msff_cfg_if.sink   cfg
);
    import msff_pkg::*;

    localparam int FILL_W = $clog2(CAP_MAX + 1);
    // compare width wide enough for both the register and the build-time limit
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [FILL_W-1:0] eff_cap;

    logic q_in_valid, q_in_ready;
    op_t  q_in_op;
    logic q_out_valid, q_out_ready;
    op_t  q_out_op;

    // capacity register; user must write it by a cfg transaction only while idle, unenforced by block
    assign cfg.ready = 1'b1;
    assign cap_next  = (cfg.valid && cfg.ready) ? cfg.data : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // saturate the written capacity at the store's row size
    always_comb
    begin
        if (CMP_W'(cap_reg) > CMP_W'(CAP_MAX))
        begin
            eff_cap = FILL_W'(CAP_MAX);
        end
        else
        begin
            eff_cap = FILL_W'(cap_reg);
        end
    end

    // front: takes request transactions and classifies them
    msff_front #(
        .NUM_STACKS (NUM_STACKS)
    ) u_front (
        .req     (req),
        .q_valid (q_in_valid),
        .q_ready (q_in_ready),
        .q_op    (q_in_op)
    );

    // short queue so the front keeps taking requests while the back works
    msff_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_op    (q_in_op),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_ready),
        .pop_op     (q_out_op)
    );

    // back: stack selection, fill update, plate store and result register
    msff_back #(
        .NUM_STACKS (NUM_STACKS),
        .CAP_MAX    (CAP_MAX),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_out_valid),
        .q_ready (q_out_ready),
        .q_op    (q_out_op),
        .eff_cap (eff_cap),
        .rsp     (rsp)
    );

endmodule

### tb/multi_stack_first_fit_tb.sv
`timescale 1ns / 100ps

module multi_stack_first_fit_tb;
    import msff_pkg::*;

    localparam int NUM_STACKS  = 64;
    localparam int CAP_MAX     = 16;
    localparam int DATA_WIDTH  = 16;
    localparam int IDLE_PCT    = 25;
    localparam int CYCLE_LIMIT = 200000;

    // one request transaction as the driver presents it
    typedef struct packed {
        func_e              func;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } plate_req_t;

    // one result transaction as the block should return it
    typedef struct packed {
        logic [VALUE_W-1:0] pop_value;
        status_e            status;
    } plate_result_t;

    logic clk;
    logic rst_n;

    msff_req_if req ();
    msff_rsp_if rsp ();
    msff_cfg_if cfg ();

    multi_stack_first_fit #(
        .NUM_STACKS (NUM_STACKS),
        .CAP_MAX    (CAP_MAX),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // pending requests, filled by the stimulus process, drained by the driver
    plate_req_t    pending_ops[$];
    // expected results in order of request acceptance
    plate_result_t expected_results[$];

    // shadow copy of the stacks and the capacity register
    logic [VALUE_W-1:0] shadow_plates [NUM_STACKS][CAP_MAX];
    int unsigned        shadow_fill   [NUM_STACKS];
    logic [CAP_W-1:0]   shadow_cap;

    // when set, neither side inserts idle cycles
    bit no_stall;

    int err_count;
    int cycle_count;
    int ops_checked;
    int full_rejects;
    int empty_pops;
    int ok_pops;
    int cap_writes;

    // -------------------------------------------------------------------------
    // clock
    // -------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // -------------------------------------------------------------------------
    // predictor: applies one operation to the shadow stacks
    // -------------------------------------------------------------------------
    function automatic plate_result_t apply_plate_op(input plate_req_t op);
        plate_result_t res;
        int unsigned   limit;
        int            s;
        res.pop_value = '0;
        res.status    = STATUS_OK;
        // capacity saturates at the physical depth; zero means every stack is full
        limit = (shadow_cap > CAP_MAX) ? CAP_MAX : shadow_cap;
        case (op.func)
            FUNC_PUSH:
            begin
                // first fit from the left
                res.status = STATUS_FULL;
                for (s = 0; s < NUM_STACKS; s++)
                begin
                    if (shadow_fill[s] < limit)
                    begin
                        shadow_plates[s][shadow_fill[s]] = op.value;
                        shadow_fill[s]++;
                        res.status = STATUS_OK;
                        break;
                    end
                end
            end
            FUNC_POP:
            begin
                // rightmost non-empty stack, empty trailing stacks skipped
                res.status = STATUS_EMPTY;
                for (s = NUM_STACKS - 1; s >= 0; s--)
                begin
                    if (shadow_fill[s] > 0)
                    begin
                        shadow_fill[s]--;
                        res.pop_value = shadow_plates[s][shadow_fill[s]];
                        res.status    = STATUS_OK;
                        break;
                    end
                end
            end
            FUNC_POP_AT:
            begin
                if (op.index < NUM_STACKS && shadow_fill[op.index] > 0)
                begin
                    shadow_fill[op.index]--;
                    res.pop_value = shadow_plates[op.index][shadow_fill[op.index]];
                end
                else
                begin
                    res.status = STATUS_EMPTY;
                end
            end
            default:
            begin
                // no-op code: no operation, zero value, status ok
            end
        endcase
        return res;
    endfunction

    // -------------------------------------------------------------------------
    // request driver: one transaction per handshake, random gaps
    // -------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_requests
        plate_req_t nxt;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else if (!req.valid || req.ready)
        begin
            // previous transaction accepted (or none pending on the bus)
            if (pending_ops.size() != 0 &&
                (no_stall || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                nxt = pending_ops.pop_front();
                req.valid       <= 1'b1;
                req.func        <= nxt.func;
                req.push_value  <= nxt.value;
                req.stack_index <= nxt.index;
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    // result sink back-pressure
    always @(posedge clk)
    begin
        rsp.ready <= rst_n && (no_stall || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // -------------------------------------------------------------------------
    // monitor: predicts on request acceptance, checks on result acceptance
    // -------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_channels
        plate_req_t    seen;
        plate_result_t want;
        if (rst_n)
        begin
            // capacity writes only happen while idle, so ordering is safe
            if (cfg.valid && cfg.ready)
                shadow_cap = cfg.data;

            // check before predicting: no result can share an edge with its request
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction: pop_value %h status %0d",
                           rsp.pop_value, rsp.status);
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    ops_checked++;
                    if (rsp.pop_value !== want.pop_value)
                    begin
                        $error("pop_value mismatch: expected %h, actual %h",
                               want.pop_value, rsp.pop_value);
                        err_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp.status);
                        err_count++;
                    end
                    case (want.status)
                        STATUS_FULL:  full_rejects++;
                        STATUS_EMPTY: empty_pops++;
                        default:      if (want.pop_value != 0) ok_pops++;
                    endcase
                end
            end

            if (req.valid && req.ready)
            begin
                seen.func  = func_e'(req.func);
                seen.value = req.push_value;
                seen.index = req.stack_index;
                expected_results.insert(expected_results.size(), apply_plate_op(seen));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // -------------------------------------------------------------------------
    // stimulus helpers
    // -------------------------------------------------------------------------
    function automatic plate_req_t mk_op(input func_e f, input logic [VALUE_W-1:0] v,
                                         input logic [INDEX_W-1:0] i);
        plate_req_t op;
        op.func  = f;
        op.value = v;
        op.index = i;
        return op;
    endfunction

    // append one request to the pending list
    function automatic void add_op(input func_e f, input logic [VALUE_W-1:0] v,
                                   input logic [INDEX_W-1:0] i);
        pending_ops.insert(pending_ops.size(), mk_op(f, v, i));
    endfunction

    // wait until every queued transaction has been answered
    task automatic wait_idle();
        while (pending_ops.size() != 0 || req.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // single capacity write over the configuration channel
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= cap;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        cap_writes++;
    endtask

    // random mix of operations; pop-at indices lean toward the filled left end
    task automatic queue_random_ops(input int count, input int push_pct);
        int     roll;
        int     pop_split;
        func_e  f;
        logic [INDEX_W-1:0] idx;
        pop_split = push_pct + (95 - push_pct) / 2;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                f = FUNC_PUSH;
            else if (roll < pop_split)
                f = FUNC_POP;
            else if (roll < 95)
                f = FUNC_POP_AT;
            else
                f = FUNC_NOP;
            idx = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom_range(0, NUM_STACKS - 1))
                                              : INDEX_W'($urandom_range(0, 11));
            add_op(f, VALUE_W'($urandom), idx);
        end
    endtask

    // -------------------------------------------------------------------------
    // main sequence
    // -------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        no_stall    = 1'b0;
        req.valid   = 1'b0;
        req.func    = FUNC_NOP;
        req.push_value  = '0;
        req.stack_index = '0;
        rsp.ready   = 1'b0;
        cfg.valid   = 1'b0;
        cfg.data    = '0;
        shadow_cap  = CAP_RESET;
        for (int s = 0; s < NUM_STACKS; s++)
            shadow_fill[s] = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: everything empty at reset capacity
        add_op(FUNC_POP,    16'h1234, 6'd0);
        add_op(FUNC_POP_AT, 16'h0000, 6'd0);
        add_op(FUNC_POP_AT, 16'hFFFF, 6'd63);
        add_op(FUNC_NOP,    16'hFFFF, 6'd63);
        add_op(FUNC_PUSH,   16'hFFFF, 6'd63);
        add_op(FUNC_PUSH,   16'h0000, 6'd0);
        add_op(FUNC_PUSH,   16'h5A5A, 6'd21);
        add_op(FUNC_POP_AT, 16'h0000, 6'd0);
        add_op(FUNC_POP_AT, 16'h0000, 6'd1);
        add_op(FUNC_POP,    16'hA5A5, 6'd42);
        add_op(FUNC_POP,    16'h0000, 6'd0);
        add_op(FUNC_POP,    16'h0000, 6'd0);
        wait_idle();

        // small capacity spills pushes into the next stack
        write_capacity(5'd2);
        add_op(FUNC_PUSH, 16'h8001, 6'd0);
        add_op(FUNC_PUSH, 16'h7FFE, 6'd0);
        add_op(FUNC_PUSH, 16'h1234, 6'd0);
        wait_idle();

        // zero capacity: pushes rejected, existing plates still drain
        write_capacity(5'd0);
        add_op(FUNC_PUSH,   16'hFFFF, 6'd0);
        add_op(FUNC_POP_AT, 16'h0000, 6'd1);
        add_op(FUNC_POP,    16'h0000, 6'd0);
        add_op(FUNC_POP,    16'h0000, 6'd0);
        add_op(FUNC_POP,    16'h0000, 6'd0);
        wait_idle();

        // capacity above the physical depth saturates
        write_capacity(5'd31);
        add_op(FUNC_PUSH,   16'hC3C3, 6'd0);
        add_op(FUNC_POP_AT, 16'h0000, 6'd0);
        wait_idle();

        // random phases, stack contents carry over between settings
        write_capacity(5'd1);
        queue_random_ops(150, 70);      // fills all stacks, then full rejects
        wait_idle();
        write_capacity(5'd3);
        queue_random_ops(150, 45);
        wait_idle();
        write_capacity(5'd16);
        queue_random_ops(200, 75);      // grows deep stacks
        wait_idle();
        write_capacity(5'd2);
        queue_random_ops(150, 40);      // capacity now below many fills
        wait_idle();
        write_capacity(5'd0);
        queue_random_ops(120, 20);
        wait_idle();
        write_capacity(5'd31);
        no_stall = 1'b1;                // back-to-back stretch
        queue_random_ops(250, 80);
        wait_idle();
        no_stall = 1'b0;
        write_capacity(5'd17);
        queue_random_ops(150, 50);
        wait_idle();
        write_capacity(5'd5);
        queue_random_ops(150, 60);
        wait_idle();
        write_capacity(5'd1);
        queue_random_ops(150, 30);
        wait_idle();
        write_capacity(5'd16);
        queue_random_ops(280, 55);
        wait_idle();

        $display("checked %0d operations across %0d capacity writes", ops_checked, cap_writes);
        $display("pops returning data %0d, empty pops %0d, rejected pushes %0d",
                 ok_pops, empty_pops, full_rejects);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
